@@ rtl/core/tsc_pkg.sv @@
// Shared types, widths and constants of the thermocouple sample conditioner.
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

	localparam int TEMP_W     = 12;
	localparam int CJ_W       = 8;
	localparam int FAULT_W    = 4;
	localparam int TIME_W     = 16;
	localparam int STREAK_W   = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_BLANK_WINDOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STREAK_NEEDED = 1'b1;

	localparam logic [TIME_W-1:0]   BLANK_RESET  = 16'd100;
	localparam logic [STREAK_W-1:0] STREAK_RESET = 8'd2;
	localparam logic [STREAK_W-1:0] RUN_MAX      = 8'd255;
	localparam logic [1:0]          MED_FULL     = 2'd3;
	localparam logic [1:0]          MED_LAST     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEDIAN,
		ST_UPDATE,
		ST_DIV_INIT,
		ST_DIVIDE,
		ST_FIX,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic median;
		logic update;
		logic div_init;
		logic div_step;
		logic div_fix;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic accepted;
		logic div_last;
		logic out_free;
	} sts_t;

	// Median of three signed values.
	function automatic logic signed [TEMP_W-1:0] mid3(
		input logic signed [TEMP_W-1:0] a,
		input logic signed [TEMP_W-1:0] b,
		input logic signed [TEMP_W-1:0] c
	);
		logic signed [TEMP_W-1:0] lo;
		logic signed [TEMP_W-1:0] hi;
		logic signed [TEMP_W-1:0] hc;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		hc = (hi < c) ? hi : c;
		return (lo > hc) ? lo : hc;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/tsc_sample_if.sv @@
// Input channel carrying one thermocouple read per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface tsc_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [tsc_pkg::TEMP_W-1:0]   hot_temp;
	logic signed [tsc_pkg::CJ_W-1:0]     cold_temp;
	logic                                fault_any;
	logic                                short_vcc;
	logic                                short_gnd;
	logic                                open_circuit;
	logic                                relay_res_mode;
	logic        [tsc_pkg::TIME_W-1:0]   ms_since_switch;

	modport source (
		output valid, hot_temp, cold_temp, fault_any, short_vcc, short_gnd,
		       open_circuit, relay_res_mode, ms_since_switch,
		input  ready
	);
	modport sink (
		input  valid, hot_temp, cold_temp, fault_any, short_vcc, short_gnd,
		       open_circuit, relay_res_mode, ms_since_switch,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/core/tsc_result_if.sv @@
// Output channel carrying one conditioned result per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface tsc_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [tsc_pkg::TEMP_W-1:0]   reported_temp;
	logic        [tsc_pkg::FAULT_W-1:0]  fault_bits;
	logic signed [tsc_pkg::CJ_W-1:0]     junction_temp;
	logic                                fresh;

	modport source (
		output valid, reported_temp, fault_bits, junction_temp, fresh,
		input  ready
	);
	modport sink (
		input  valid, reported_temp, fault_bits, junction_temp, fresh,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/core/tsc_ctrl.sv @@
// Sequencing state machine of the sample conditioner.
`timescale 1ns / 1ps
`default_nettype none

module tsc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tsc_pkg::sts_t sts,
	output tsc_pkg::cmd_t cmd
);
	import tsc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MEDIAN;
			end
			ST_MEDIAN: begin
				state_d = sts.accepted ? ST_UPDATE : ST_DONE;
			end
			ST_UPDATE:   state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (sts.div_last) state_d = ST_FIX;
			end
			ST_FIX:      state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_MEDIAN:   cmd.median   = 1'b1;
			ST_UPDATE:   cmd.update   = 1'b1;
			ST_DIV_INIT: cmd.div_init = 1'b1;
			ST_DIVIDE:   cmd.div_step = 1'b1;
			ST_FIX:      cmd.div_fix  = 1'b1;
			ST_DONE:     cmd.out_load = sts.out_free;
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/tsc_datapath.sv @@
// Datapath: classification, median history, moving average, divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module tsc_datapath #(
	parameter int AVG_DEPTH = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tsc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tsc_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [tsc_pkg::TEMP_W-1:0]     hot_temp,
	input  logic signed [tsc_pkg::CJ_W-1:0]       cold_temp,
	input  logic                                  fault_any,
	input  logic                                  short_vcc,
	input  logic                                  short_gnd,
	input  logic                                  open_circuit,
	input  logic                                  relay_res_mode,
	input  logic [tsc_pkg::TIME_W-1:0]            ms_since_switch,
	input  tsc_pkg::cmd_t                         cmd,
	output tsc_pkg::sts_t                         sts,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic signed [tsc_pkg::TEMP_W-1:0]     reported_temp,
	output logic [tsc_pkg::FAULT_W-1:0]           fault_bits,
	output logic signed [tsc_pkg::CJ_W-1:0]       junction_temp,
	output logic                                  fresh
);
	import tsc_pkg::*;

	localparam int SUM_W  = TEMP_W + 1 + $clog2(AVG_DEPTH);
	localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
	localparam int POS_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int REM_W  = CNT_W + 1;

	// Configuration registers.
	logic [TIME_W-1:0]   blank_q;
	logic [STREAK_W-1:0] streak_q;

	// Captured item.
	logic signed [TEMP_W-1:0] hot_q;
	logic signed [CJ_W-1:0]   cold_q;
	logic [FAULT_W-1:0]       faults_q;
	logic                     accepted_q;
	logic                     use_med_q;

	// Median history and valid run.
	logic signed [TEMP_W-1:0] hist_q [3];
	logic [1:0]               mpos_q;
	logic [1:0]               mcount_q;
	logic [STREAK_W-1:0]      run_q;
	logic signed [TEMP_W-1:0] tc_q;

	// Moving average.
	logic signed [TEMP_W-1:0] buf_q [AVG_DEPTH];
	logic signed [SUM_W-1:0]  sum_q;
	logic [POS_W-1:0]         pos_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [TEMP_W-1:0] held_q;

	// Divider.
	logic                     neg_q;
	logic [SUM_W-1:0]         quo_q;
	logic [CNT_W-1:0]         rem_q;
	logic [STEP_W-1:0]        step_q;

	logic                     out_valid_q;

	logic [FAULT_W-1:0]       faults_c;
	logic                     valid_c;
	logic [STREAK_W-1:0]      run_next;
	logic [1:0]               mcount_next;
	logic [1:0]               mpos_next;
	logic                     avg_full;
	logic signed [TEMP_W-1:0] avg_old;
	logic [REM_W-1:0]         shifted;
	logic                     take;
	logic [SUM_W-1:0]         quo_signed;

	assign faults_c    = {open_circuit, short_gnd, short_vcc, fault_any};
	assign valid_c     = (faults_c == '0) && !relay_res_mode && (ms_since_switch >= blank_q);
	assign run_next    = (run_q != RUN_MAX) ? run_q + 1'b1 : run_q;
	assign mcount_next = (mcount_q != MED_FULL) ? mcount_q + 1'b1 : mcount_q;
	assign mpos_next   = (mpos_q == MED_LAST) ? 2'd0 : mpos_q + 1'b1;

	assign avg_full = (count_q == CNT_W'(AVG_DEPTH));
	assign avg_old  = avg_full ? buf_q[pos_q] : '0;

	// One restoring division step on the magnitude of the sum.
	assign shifted    = {rem_q, quo_q[SUM_W-1]};
	assign take       = (shifted >= {1'b0, count_q});
	assign quo_signed = neg_q ? (SUM_W'(0) - quo_q) : quo_q;

	assign sts.accepted = accepted_q;
	assign sts.div_last = (step_q == STEP_W'(1));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q  <= BLANK_RESET;
			streak_q <= STREAK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLANK_WINDOW:  blank_q  <= cfg_data[TIME_W-1:0];
				REG_STREAK_NEEDED: streak_q <= cfg_data[STREAK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= 1'b0;
			use_med_q  <= 1'b0;
			mpos_q     <= '0;
			mcount_q   <= '0;
			run_q      <= '0;
			sum_q      <= '0;
			pos_q      <= '0;
			count_q    <= '0;
			held_q     <= '0;
			neg_q      <= 1'b0;
			step_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				if (valid_c) begin
					run_q      <= run_next;
					mcount_q   <= mcount_next;
					mpos_q     <= mpos_next;
					use_med_q  <= (mcount_next == MED_FULL);
					accepted_q <= (run_next >= streak_q);
				end else begin
					run_q      <= '0;
					accepted_q <= 1'b0;
				end
			end
			if (cmd.update) begin
				sum_q <= sum_q - SUM_W'(avg_old) + SUM_W'(tc_q);
				if (!avg_full) count_q <= count_q + 1'b1;
				pos_q <= (pos_q == POS_W'(AVG_DEPTH - 1)) ? '0 : pos_q + 1'b1;
			end
			if (cmd.div_init) begin
				neg_q  <= sum_q[SUM_W-1];
				step_q <= STEP_W'(SUM_W);
			end else if (cmd.div_step) begin
				step_q <= step_q - 1'b1;
			end
			if (cmd.div_fix) begin
				held_q <= quo_signed[TEMP_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hot_q    <= hot_temp;
			cold_q   <= cold_temp;
			faults_q <= faults_c;
			if (valid_c) hist_q[mpos_q] <= hot_temp;
		end
		if (cmd.median) begin
			tc_q <= use_med_q ? mid3(hist_q[0], hist_q[1], hist_q[2]) : hot_q;
		end
		if (cmd.update) begin
			buf_q[pos_q] <= tc_q;
		end
		if (cmd.div_init) begin
			quo_q <= sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= take ? CNT_W'(shifted - {1'b0, count_q}) : CNT_W'(shifted);
			quo_q <= {quo_q[SUM_W-2:0], take};
		end
		if (cmd.out_load) begin
			reported_temp <= held_q;
			fault_bits    <= faults_q;
			junction_temp <= cold_q;
			fresh         <= accepted_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/thermocouple_sample_conditioner.sv @@
// Top level of the thermocouple sample conditioner.
`timescale 1ns / 1ps
`default_nettype none

// Conditions one thermocouple read per input transfer and returns exactly one
// result per read. A read is valid when no fault flag is set, the relay is in
// thermocouple mode and ms_since_switch has reached blank_window_ms. Valid reads
// pass through a three-point median (once three have been seen) and, after
// streak_needed consecutive valid reads, into an AVG_DEPTH-sample moving average
// whose sum is divided by the fill count, truncated toward zero. Otherwise the
// last average is repeated with fresh low. A read that updates the average
// passes median, update, divider setup, a restoring division of the SUM_W-bit
// sum (SUM_W = 13 + clog2(AVG_DEPTH)) that dominates at one quotient bit per
// cycle, and a sign fix before the next read is taken; other reads skip all
// but the median. The finished result waits in an output register while the
// next read is taken. The user must write configuration only while idle.
module thermocouple_sample_conditioner #(
	parameter int AVG_DEPTH = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsc_pkg::CFG_DATA_W-1:0] cfg_data,
	tsc_sample_if.sink                     samples,
	tsc_result_if.source                   results
);
	import tsc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tsc_datapath #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.hot_temp        (samples.hot_temp),
		.cold_temp       (samples.cold_temp),
		.fault_any       (samples.fault_any),
		.short_vcc       (samples.short_vcc),
		.short_gnd       (samples.short_gnd),
		.open_circuit    (samples.open_circuit),
		.relay_res_mode  (samples.relay_res_mode),
		.ms_since_switch (samples.ms_since_switch),
		.cmd             (cmd),
		.sts             (sts),
		.out_ready       (results.ready),
		.out_valid       (results.valid),
		.reported_temp   (results.reported_temp),
		.fault_bits      (results.fault_bits),
		.junction_temp   (results.junction_temp),
		.fresh           (results.fresh)
	);

endmodule

`default_nettype wire
